// ===== design/block_majority_binarize_assert.svh =====
// assertion macros for the block majority binarizer
// no dependencies; included by the top level
`ifndef BLOCK_MAJORITY_BINARIZE_ASSERT_SVH
`define BLOCK_MAJORITY_BINARIZE_ASSERT_SVH

// same-cycle implication
`define BMB_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bmb_pkg.sv =====
// shared constants and types for the block majority binarizer
// no dependencies
`default_nettype none

package bmb_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_GRID_COLS    = 64;
    localparam int DEF_MAX_IMAGE_WIDTH  = 1024;
    localparam int DEF_MAX_IMAGE_HEIGHT = 1024;

    // cell rows are capped at a fixed count
    localparam int GRID_ROWS_CAP = 64;
    localparam int ROW_W         = $clog2(GRID_ROWS_CAP + 1);

    // configuration register widths and reset values
    localparam int IMG_CFG_W  = 11;
    localparam int GRID_CFG_W = 7;
    localparam logic [IMG_CFG_W-1:0]  RST_IMAGE_WIDTH  = IMG_CFG_W'(1024);
    localparam logic [IMG_CFG_W-1:0]  RST_IMAGE_HEIGHT = IMG_CFG_W'(1024);
    localparam logic [GRID_CFG_W-1:0] RST_GRID_COLS    = GRID_CFG_W'(64);
    localparam logic [GRID_CFG_W-1:0] RST_GRID_ROWS    = GRID_CFG_W'(64);

    // register indexes on the apb port
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID_COLS    = 2'd2;
    localparam logic [1:0] REG_GRID_ROWS    = 2'd3;

    // luma test scaled by 1000: 299r + 587g + 114b < 128000
    localparam int LUMA_W     = 18;
    localparam int LUMA_R     = 299;
    localparam int LUMA_G     = 587;
    localparam int LUMA_B     = 114;
    localparam int DARK_LIMIT = 128000;

    // result queue
    localparam int QD  = 4;
    localparam int QLW = $clog2(QD + 1);

    localparam int CELL_W = 6;

    typedef struct packed {
        logic              valid;   // pixel accepted
        logic              upd;     // read-modify-write the column counter
        logic              clear;   // first pixel of the cell band
        logic              dark;
        logic              emit;    // final pixel of a cell
        logic              err;     // size error at frame start
        logic              last;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
    } t_pix_ctl;

    typedef struct packed {
        logic              wall;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              last_cell;
        logic              size_error;
    } t_result;

endpackage

`default_nettype wire

// ===== design/bmb_div.sv =====
// restoring divider, one quotient bit per cycle
// uses no package items
`default_nettype none

module bmb_div #(
    parameter int NW = 11,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DW:0]      r_rem;
    logic [NW-1:0]    r_num;
    logic [NW-1:0]    r_quot;
    logic [DW:0]      w_trial;
    logic             w_fit;

    assign w_trial = {r_rem[DW-1:0], r_num[NW-1]};
    assign w_fit   = (w_trial >= {1'b0, i_den});
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_num  <= i_num;
            r_quot <= '0;
        end else if (o_busy) begin
            r_rem  <= w_fit ? (w_trial - {1'b0, i_den}) : w_trial;
            r_num  <= NW'({r_num, 1'b0});
            r_quot <= NW'({r_quot, w_fit});
        end
    end

endmodule

`default_nettype wire

// ===== design/bmb_cnt.sv =====
// per-column dark counter memory with read-modify-write pipeline and wall decision
// depends on bmb_pkg
`default_nettype none

module bmb_cnt #(
    parameter int SLOTS = 64,
    parameter int XW    = 11,
    parameter int YW    = 11,
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNTW = XW + YW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmb_pkg::t_pix_ctl i_ctl,
    input  logic [SW-1:0]     i_slot,
    input  logic [XW-1:0]     i_cw,
    input  logic [YW-1:0]     i_ch,
    output logic              o_res_valid,
    output bmb_pkg::t_result  o_res,
    output logic [1:0]        o_inflight
);

    import bmb_pkg::*;

    logic [CNTW-1:0] r_mem [SLOTS];
    logic [CNTW-1:0] r_rd;

    t_pix_ctl        r_s1;
    logic [SW-1:0]   r_s1_slot;
    logic [XW-1:0]   r_s1_cw;
    logic [YW-1:0]   r_s1_ch;
    logic            r_byp;
    logic [CNTW-1:0] r_byp_d;

    t_pix_ctl        r_s2;
    logic [CNTW-1:0] r_s2_cnt;
    logic [CNTW-1:0] r_s2_area;

    logic [CNTW-1:0] w_base;
    logic [CNTW-1:0] w_cnt;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_slot];
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.upd) begin
            r_mem[r_s1_slot] <= w_cnt;
        end
    end

    // the write of the item ahead lands in the same cycle as this read
    always_comb begin
        if (r_s1.clear) begin
            w_base = '0;
        end else if (r_byp) begin
            w_base = r_byp_d;
        end else begin
            w_base = r_rd;
        end
        w_cnt = w_base + CNTW'(r_s1.dark);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_byp <= 1'b0;
        end else begin
            r_s1  <= i_ctl;
            r_s2  <= r_s1;
            r_byp <= r_s1.upd && (r_s1_slot == i_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_slot <= i_slot;
        r_s1_cw   <= i_cw;
        r_s1_ch   <= i_ch;
        r_byp_d   <= w_cnt;
        r_s2_cnt  <= w_cnt;
        r_s2_area <= CNTW'(r_s1_cw * r_s1_ch);
    end

    always_comb begin
        o_res = '0;
        if (r_s2.err) begin
            o_res.size_error = 1'b1;
        end else begin
            o_res.wall      = ({r_s2_cnt, 1'b0} >= {1'b0, r_s2_area});
            o_res.cell_x    = r_s2.cell_x;
            o_res.cell_y    = r_s2.cell_y;
            o_res.last_cell = r_s2.last;
        end
    end

    assign o_res_valid = r_s2.emit || r_s2.err;
    assign o_inflight  = {1'b0, r_s1.valid} + {1'b0, r_s2.valid};

endmodule

`default_nettype wire

// ===== design/bmb_outq.sv =====
// small result queue that decouples the pipeline from the output stall
// depends on bmb_pkg
`default_nettype none

module bmb_outq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  bmb_pkg::t_result         i_item,
    input  logic                     i_pop,
    output bmb_pkg::t_result         o_head,
    output logic                     o_valid,
    output logic [bmb_pkg::QLW-1:0]  o_level
);

    import bmb_pkg::*;

    t_result        r_q [QD];
    t_result        n_q [QD];
    logic [QLW-1:0] r_level;
    logic [QLW-1:0] n_level;
    logic [QLW-1:0] w_wr_idx;
    logic           w_pop;

    assign w_pop   = i_pop && (r_level != '0);
    assign o_valid = (r_level != '0);
    assign o_head  = r_q[0];
    assign o_level = r_level;

    // head stays at entry zero, the rest shift down on a pop
    always_comb begin
        w_wr_idx = r_level - QLW'(w_pop);
        for (int k = 0; k < QD; k++) begin
            n_q[k] = r_q[k];
        end
        for (int k = 0; k < QD - 1; k++) begin
            if (w_pop) begin
                n_q[k] = r_q[k+1];
            end
        end
        for (int k = 0; k < QD; k++) begin
            if (i_push && (QLW'(k) == w_wr_idx)) begin
                n_q[k] = i_item;
            end
        end
        n_level = r_level + QLW'(i_push) - QLW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QD; k++) begin
            r_q[k] <= n_q[k];
        end
    end

endmodule

`default_nettype wire

// ===== design/block_majority_binarize.sv =====
// channel   | direction | handshake          | payload
// pixel     | in        | i_valid / o_stall  | i_red, i_green, i_blue
// cell      | out       | o_valid / i_stall  | o_wall, o_cell_x, o_cell_y, o_last_cell, o_size_error
// config    | in        | apb psel / penable | paddr, pwdata, prdata
//
// one pixel per cycle while o_stall is low; a cell item passes counter stages s1 and s2, then the result queue
// after reset or any register write the cell size is recomputed by two bit-serial
// dividers; the first pixel of a frame waits on it
// counters live in one memory indexed by cell column, read in the cycle before the update
// a four-entry result queue with credit on pixel intake absorbs output stalls
// reset is synchronous; no clearing pass, a band's first pixel overwrites its counter
//
// top level of the block majority binarizer; depends on bmb_pkg, bmb_div, bmb_cnt,
// bmb_outq and the assertion macro header
`default_nettype none

`include "block_majority_binarize_assert.svh"

module block_majority_binarize #(
    parameter int MAX_GRID_COLS    = bmb_pkg::DEF_MAX_GRID_COLS,
    parameter int MAX_IMAGE_WIDTH  = bmb_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_IMAGE_HEIGHT = bmb_pkg::DEF_MAX_IMAGE_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_wall,
    output logic [5:0]  o_cell_x,
    output logic [5:0]  o_cell_y,
    output logic        o_last_cell,
    output logic        o_size_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bmb_pkg::*;

    localparam int XW   = $clog2(MAX_IMAGE_WIDTH + 1);
    localparam int YW   = $clog2(MAX_IMAGE_HEIGHT + 1);
    localparam int CW   = $clog2(MAX_GRID_COLS + 1);
    localparam int SW   = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;

    // configuration registers
    logic [IMG_CFG_W-1:0]  r_image_width;
    logic [IMG_CFG_W-1:0]  r_image_height;
    logic [GRID_CFG_W-1:0] r_grid_cols;
    logic [GRID_CFG_W-1:0] r_grid_rows;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_grid_cols    <= RST_GRID_COLS;
            r_grid_rows    <= RST_GRID_ROWS;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[IMG_CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[IMG_CFG_W-1:0];
                REG_GRID_COLS:    r_grid_cols    <= pwdata[GRID_CFG_W-1:0];
                REG_GRID_ROWS:    r_grid_rows    <= pwdata[GRID_CFG_W-1:0];
                default:          r_grid_rows    <= r_grid_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            REG_GRID_COLS:    prdata = 32'(r_grid_cols);
            REG_GRID_ROWS:    prdata = 32'(r_grid_rows);
            default:          prdata = '0;
        endcase
    end

    // frame geometry from the live registers
    logic [XW-1:0]    w_w_c;
    logic [YW-1:0]    w_h_c;
    logic [CW-1:0]    w_cols_c;
    logic [ROW_W-1:0] w_rows_c;
    logic [XW-1:0]    w_quot_x;
    logic [YW-1:0]    w_quot_y;
    logic             w_busy_x;
    logic             w_busy_y;
    logic             w_div_start;
    logic             w_geom_ok;
    logic             r_need_div;
    logic [XW-1:0]    w_geo_cw;
    logic [YW-1:0]    w_geo_ch;
    logic [XW-1:0]    w_geo_fw;
    logic [YW-1:0]    w_geo_fh;
    logic             w_geo_bad;

    assign w_w_c = (32'(r_image_width) > 32'(MAX_IMAGE_WIDTH)) ?
                   XW'(MAX_IMAGE_WIDTH) : XW'(r_image_width);
    assign w_h_c = (32'(r_image_height) > 32'(MAX_IMAGE_HEIGHT)) ?
                   YW'(MAX_IMAGE_HEIGHT) : YW'(r_image_height);
    assign w_cols_c = (32'(r_grid_cols) > 32'(MAX_GRID_COLS)) ?
                      CW'(MAX_GRID_COLS) : CW'(r_grid_cols);
    assign w_rows_c = (32'(r_grid_rows) > 32'(GRID_ROWS_CAP)) ?
                      ROW_W'(GRID_ROWS_CAP) : ROW_W'(r_grid_rows);

    assign w_div_start = r_need_div && !w_busy_x && !w_busy_y;
    assign w_geom_ok   = !r_need_div && !w_busy_x && !w_busy_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_div <= 1'b1;
        end else if (w_cfg_wr) begin
            r_need_div <= 1'b1;
        end else if (w_div_start) begin
            r_need_div <= 1'b0;
        end
    end

    bmb_div #(.NW(XW), .DW(CW)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_w_c),
        .i_den   (w_cols_c),
        .o_busy  (w_busy_x),
        .o_quot  (w_quot_x)
    );

    bmb_div #(.NW(YW), .DW(ROW_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_h_c),
        .i_den   (w_rows_c),
        .o_busy  (w_busy_y),
        .o_quot  (w_quot_y)
    );

    assign w_geo_cw  = (w_cols_c == '0) ? '0 : w_quot_x;
    assign w_geo_ch  = (w_rows_c == '0) ? '0 : w_quot_y;
    assign w_geo_fw  = (w_w_c == '0) ? XW'(1) : w_w_c;
    assign w_geo_fh  = (w_h_c == '0) ? YW'(1) : w_h_c;
    assign w_geo_bad = (w_geo_cw == '0) || (w_geo_ch == '0);

    // geometry latched at the first pixel of a frame
    logic [XW-1:0]    r_fr_w;
    logic [YW-1:0]    r_fr_h;
    logic [CW-1:0]    r_fr_cols;
    logic [ROW_W-1:0] r_fr_rows;
    logic [XW-1:0]    r_cell_width;
    logic [YW-1:0]    r_cell_height;
    logic             r_frame_bad;

    // raster position
    logic [XW-1:0]    r_pixel_x, n_pixel_x;
    logic [YW-1:0]    r_pixel_y, n_pixel_y;
    logic [CW-1:0]    r_col_index, n_col_index;
    logic [ROW_W-1:0] r_row_index, n_row_index;
    logic [XW-1:0]    r_col_offset, n_col_offset;
    logic [YW-1:0]    r_row_offset, n_row_offset;

    logic             w_at_start;
    logic             w_accept;
    logic [XW-1:0]    f_fw;
    logic [YW-1:0]    f_fh;
    logic [CW-1:0]    f_cols;
    logic [ROW_W-1:0] f_rows;
    logic [XW-1:0]    f_cw;
    logic [YW-1:0]    f_ch;
    logic             f_bad;
    logic             w_px_last;
    logic             w_py_last;
    logic             w_last_col;
    logic             w_last_row;
    logic             w_col_end;
    logic             w_row_end;
    logic [LUMA_W-1:0] w_luma;
    logic             w_dark;

    assign w_at_start = (r_pixel_x == '0) && (r_pixel_y == '0);
    assign w_accept   = i_valid && !o_stall;

    assign f_fw   = w_at_start ? w_geo_fw  : r_fr_w;
    assign f_fh   = w_at_start ? w_geo_fh  : r_fr_h;
    assign f_cols = w_at_start ? w_cols_c  : r_fr_cols;
    assign f_rows = w_at_start ? w_rows_c  : r_fr_rows;
    assign f_cw   = w_at_start ? w_geo_cw  : r_cell_width;
    assign f_ch   = w_at_start ? w_geo_ch  : r_cell_height;
    assign f_bad  = w_at_start ? w_geo_bad : r_frame_bad;

    assign w_px_last  = ((XW+1)'(r_pixel_x) + (XW+1)'(1)) >= (XW+1)'(f_fw);
    assign w_py_last  = ((YW+1)'(r_pixel_y) + (YW+1)'(1)) >= (YW+1)'(f_fh);
    assign w_last_col = ((CW+1)'(r_col_index) + (CW+1)'(1)) >= (CW+1)'(f_cols);
    assign w_last_row = ((ROW_W+1)'(r_row_index) + (ROW_W+1)'(1)) >= (ROW_W+1)'(f_rows);

    // a bad frame only walks the raster
    assign w_col_end = !f_bad && (w_last_col ? w_px_last :
                       (((XW+1)'(r_col_offset) + (XW+1)'(1)) >= (XW+1)'(f_cw)));
    assign w_row_end = !f_bad && (w_last_row ? w_py_last :
                       (((YW+1)'(r_row_offset) + (YW+1)'(1)) >= (YW+1)'(f_ch)));

    assign w_luma = LUMA_W'(LUMA_R * 32'(i_red) + LUMA_G * 32'(i_green)
                          + LUMA_B * 32'(i_blue));
    assign w_dark = (w_luma < LUMA_W'(DARK_LIMIT));

    always_comb begin
        n_pixel_x    = r_pixel_x;
        n_pixel_y    = r_pixel_y;
        n_col_index  = r_col_index;
        n_row_index  = r_row_index;
        n_col_offset = r_col_offset;
        n_row_offset = r_row_offset;
        if (w_accept) begin
            if (w_px_last) begin
                n_pixel_x    = '0;
                n_col_index  = '0;
                n_col_offset = '0;
                if (w_py_last) begin
                    n_pixel_y    = '0;
                    n_row_index  = '0;
                    n_row_offset = '0;
                end else begin
                    n_pixel_y = r_pixel_y + YW'(1);
                    if (w_row_end) begin
                        n_row_offset = '0;
                        n_row_index  = r_row_index + ROW_W'(1);
                    end else begin
                        n_row_offset = r_row_offset + YW'(1);
                    end
                end
            end else begin
                n_pixel_x = r_pixel_x + XW'(1);
                if (w_col_end) begin
                    n_col_offset = '0;
                    n_col_index  = r_col_index + CW'(1);
                end else begin
                    n_col_offset = r_col_offset + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_x    <= '0;
            r_pixel_y    <= '0;
            r_col_index  <= '0;
            r_row_index  <= '0;
            r_col_offset <= '0;
            r_row_offset <= '0;
        end else begin
            r_pixel_x    <= n_pixel_x;
            r_pixel_y    <= n_pixel_y;
            r_col_index  <= n_col_index;
            r_row_index  <= n_row_index;
            r_col_offset <= n_col_offset;
            r_row_offset <= n_row_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_at_start) begin
            r_fr_w        <= w_geo_fw;
            r_fr_h        <= w_geo_fh;
            r_fr_cols     <= w_cols_c;
            r_fr_rows     <= w_rows_c;
            r_cell_width  <= w_geo_cw;
            r_cell_height <= w_geo_ch;
            r_frame_bad   <= w_geo_bad;
        end
    end

    // counter pipeline
    t_pix_ctl      w_ctl;
    logic [XW-1:0] w_cw;
    logic [YW-1:0] w_ch;
    logic          w_res_valid;
    t_result       w_res;
    logic [1:0]    w_inflight;

    always_comb begin
        w_ctl        = '0;
        w_ctl.valid  = w_accept;
        w_ctl.upd    = w_accept && !f_bad;
        w_ctl.clear  = (r_row_offset == '0) && (r_col_offset == '0);
        w_ctl.dark   = w_dark;
        w_ctl.emit   = w_accept && w_col_end && w_row_end;
        w_ctl.err    = w_accept && w_at_start && w_geo_bad;
        w_ctl.last   = w_last_col && w_last_row;
        w_ctl.cell_x = CELL_W'(r_col_index);
        w_ctl.cell_y = CELL_W'(r_row_index);
    end

    // at a cell's final pixel the offsets count exactly the cell size minus one
    assign w_cw = r_col_offset + XW'(1);
    assign w_ch = r_row_offset + YW'(1);

    bmb_cnt #(.SLOTS(MAX_GRID_COLS), .XW(XW), .YW(YW)) u_cnt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_slot      (r_col_index[SW-1:0]),
        .i_cw        (w_cw),
        .i_ch        (w_ch),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_inflight  (w_inflight)
    );

    // result queue and intake credit
    t_result        w_head;
    logic [QLW-1:0] w_level;
    logic [QLW:0]   w_occupancy;

    bmb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_item  (w_res),
        .i_pop   (o_valid && !i_stall),
        .o_head  (w_head),
        .o_valid (o_valid),
        .o_level (w_level)
    );

    assign w_occupancy = (QLW+1)'(w_level) + (QLW+1)'(w_inflight);
    assign o_stall     = !((w_occupancy < (QLW+1)'(QD)) && (!w_at_start || w_geom_ok));

    assign o_wall       = w_head.wall;
    assign o_cell_x     = w_head.cell_x;
    assign o_cell_y     = w_head.cell_y;
    assign o_last_cell  = w_head.last_cell;
    assign o_size_error = w_head.size_error;

    `BMB_ASSERT_NOW(a_credit_bound, i_clk, i_rst_n, 1'b1, w_occupancy <= (QLW+1)'(QD), "result queue credit exceeded")
    `BMB_ASSERT_NEXT(a_cfg_redivide, i_clk, i_rst_n, w_cfg_wr, !w_geom_ok, "geometry not recomputed after register write")
    `BMB_ASSERT_NOW(a_error_clean, i_clk, i_rst_n, o_valid && o_size_error, !o_wall && !o_last_cell && (o_cell_x == '0) && (o_cell_y == '0), "size error item carries cell data")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for block_majority_binarize: raster frames of rgb pixels in, cell items out
// depends on bmb_pkg and the design sources; an in-bench model predicts each cell item of untyped frames

module tb_top;
    import bmb_pkg::*;

    localparam int unsigned DARK_SUM  = 128000;
    localparam int unsigned RAND_PIX  = 1950;
    localparam int unsigned CYCLE_CAP = 400000;
    localparam int unsigned QUIET_CYC = 24;

    typedef enum int {
        PIX_FIXED,
        PIX_RANDOM,
        PIX_GRAY_EDGE,
        PIX_DARKISH,
        PIX_BRIGHTISH
    } pix_mode_e;

    typedef struct {
        int unsigned w;
        int unsigned h;
        int unsigned cols;
        int unsigned rows;
        pix_mode_e   mode;
        logic [23:0] color;
        bit          typed;       // one-result frame, expected item given in the row
        t_result     want;
        int unsigned split;       // pixel index where grid_cols is rewritten mid-frame
        int unsigned split_cols;
    } frame_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_red = 8'd0;
    logic [7:0]  i_green = 8'd0;
    logic [7:0]  i_blue = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_wall;
    logic [5:0]  o_cell_x;
    logic [5:0]  o_cell_y;
    logic        o_last_cell;
    logic        o_size_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // register copies as written
    logic [10:0] cfg_width = RST_IMAGE_WIDTH;
    logic [10:0] cfg_height = RST_IMAGE_HEIGHT;
    logic [6:0]  cfg_cols = RST_GRID_COLS;
    logic [6:0]  cfg_rows = RST_GRID_ROWS;

    // scan position and frame geometry of the model
    int unsigned dark_tally [64];
    int unsigned pix_x = 0, pix_y = 0;
    int unsigned cx_idx = 0, cy_idx = 0, cx_off = 0, cy_off = 0;
    int unsigned cell_w = 0, cell_h = 0;
    int unsigned frm_w = 1, frm_h = 1, frm_cols = 1, frm_rows = 1;
    bit          frm_bad = 1'b0;

    t_result     cells_due [$];
    t_result     cell_want;
    frame_t      plan [$];
    int unsigned fed = 0;
    int unsigned fails = 0;
    int unsigned cycles = 0;
    bit          calm = 1'b0;

    block_majority_binarize u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_wall       (o_wall),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_last_cell  (o_last_cell),
        .o_size_error (o_size_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= CYCLE_CAP);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned sat(input int unsigned v, input int unsigned cap);
        return (v > cap) ? cap : v;
    endfunction

    function automatic int unsigned frame_pixels();
        int unsigned w;
        int unsigned h;
        w = sat(cfg_width, DEF_MAX_IMAGE_WIDTH);
        h = sat(cfg_height, DEF_MAX_IMAGE_HEIGHT);
        return (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
    endfunction

    function automatic t_result mk_cell(input bit wall, input bit last, input bit err);
        t_result c;
        c = '0;
        c.wall = wall;
        c.last_cell = last;
        c.size_error = err;
        return c;
    endfunction

    function automatic logic [23:0] make_pixel(input pix_mode_e mode, input logic [23:0] color);
        case (mode)
            PIX_FIXED:     return color;
            PIX_GRAY_EDGE: return {8'($urandom_range(125, 130)), 8'($urandom_range(125, 130)),
                                   8'($urandom_range(125, 130))};
            PIX_DARKISH:   return {8'($urandom_range(0, 150)), 8'($urandom_range(0, 150)),
                                   8'($urandom_range(0, 150))};
            PIX_BRIGHTISH: return {8'($urandom_range(100, 255)), 8'($urandom_range(100, 255)),
                                   8'($urandom_range(100, 255))};
            default:       return 24'($urandom);
        endcase
    endfunction

    // latch geometry at the first pixel of a frame
    task automatic open_frame();
        int unsigned w;
        int unsigned h;
        w = sat(cfg_width, DEF_MAX_IMAGE_WIDTH);
        h = sat(cfg_height, DEF_MAX_IMAGE_HEIGHT);
        frm_cols = sat(cfg_cols, DEF_MAX_GRID_COLS);
        frm_rows = sat(cfg_rows, GRID_ROWS_CAP);
        cell_w = (frm_cols != 0) ? w / frm_cols : 0;
        cell_h = (frm_rows != 0) ? h / frm_rows : 0;
        frm_w = (w != 0) ? w : 1;
        frm_h = (h != 0) ? h : 1;
        frm_bad = (cell_w == 0 || cell_h == 0);
    endtask

    task automatic step_pos(input bit col_end, input bit row_end);
        if (pix_x + 1 >= frm_w) begin
            pix_x = 0;
            cx_idx = 0;
            cx_off = 0;
            if (pix_y + 1 >= frm_h) begin
                pix_y = 0;
                cy_idx = 0;
                cy_off = 0;
            end else begin
                pix_y++;
                if (row_end) begin
                    cy_off = 0;
                    cy_idx++;
                end else begin
                    cy_off++;
                end
            end
        end else begin
            pix_x++;
            if (col_end) begin
                cx_off = 0;
                cx_idx++;
            end else begin
                cx_off++;
            end
        end
    endtask

    // one pixel through the model; hit when it finishes a cell or flags a bad frame
    task automatic bin_pixel(input logic [23:0] px, output bit hit, output t_result res);
        int unsigned     luma;
        int unsigned     slot;
        int unsigned     cw;
        int unsigned     ch;
        longint unsigned area;
        bit              dark;
        bit              last_col;
        bit              last_row;
        bit              col_end;
        bit              row_end;
        hit = 1'b0;
        res = '0;
        luma = 299 * px[23:16] + 587 * px[15:8] + 114 * px[7:0];
        dark = (luma < DARK_SUM);
        if (pix_x == 0 && pix_y == 0) begin
            open_frame();
            if (frm_bad) begin
                hit = 1'b1;
                res.size_error = 1'b1;
            end
        end
        if (frm_bad) begin
            step_pos(1'b0, 1'b0);
        end else begin
            last_col = (cx_idx + 1 >= frm_cols);
            last_row = (cy_idx + 1 >= frm_rows);
            col_end = last_col ? (pix_x + 1 >= frm_w) : (cx_off + 1 >= cell_w);
            row_end = last_row ? (pix_y + 1 >= frm_h) : (cy_off + 1 >= cell_h);
            slot = cx_idx % 64;
            // first pixel of the band restarts the column count
            if (cy_off == 0 && cx_off == 0) begin
                dark_tally[slot] = 0;
            end
            if (dark) begin
                dark_tally[slot]++;
            end
            if (col_end && row_end) begin
                cw = last_col ? frm_w - cx_idx * cell_w : cell_w;
                ch = last_row ? frm_h - cy_idx * cell_h : cell_h;
                area = 64'(cw) * 64'(ch);
                res.wall = (64'(dark_tally[slot]) * 2 >= area);
                res.cell_x = CELL_W'(cx_idx);
                res.cell_y = CELL_W'(cy_idx);
                res.last_cell = last_col && last_row;
                hit = 1'b1;
            end
            step_pos(col_end, row_end);
        end
    endtask

    task automatic check_field(input string name, input logic [5:0] want, input logic [5:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 24);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (cells_due.size() == 0) begin
                $error("cell item with nothing expected: x=%0d y=%0d", o_cell_x, o_cell_y);
                fails++;
            end else begin
                cell_want = cells_due.pop_front();
                check_field("wall", cell_want.wall, o_wall);
                check_field("cell_x", cell_want.cell_x, o_cell_x);
                check_field("cell_y", cell_want.cell_y, o_cell_y);
                check_field("last_cell", cell_want.last_cell, o_last_cell);
                check_field("size_error", cell_want.size_error, o_size_error);
            end
        end
    end

    task automatic settle();
        while (cells_due.size() != 0) @(posedge i_clk);
        // covers the output pipe and the divider rerun after a write
        repeat (QUIET_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = 11'(val);
            REG_IMAGE_HEIGHT: cfg_height = 11'(val);
            REG_GRID_COLS:    cfg_cols = 7'(val);
            default:          cfg_rows = 7'(val);
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [23:0] px, input bit typed, input t_result want);
        bit      hit;
        t_result got;
        while (!calm && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_red, i_green, i_blue} <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bin_pixel(px, hit, got);
        if (hit) begin
            cells_due.push_back(typed ? want : got);
        end
        if (!frm_bad) begin
            fed++;
        end
        @(negedge i_clk);
    endtask

    task automatic run_frame(input frame_t f, input bit all_regs);
        int unsigned npix;
        int unsigned k;
        if (all_regs || f.w != cfg_width || $urandom_range(1)) set_reg(REG_IMAGE_WIDTH, f.w);
        if (all_regs || f.h != cfg_height || $urandom_range(1)) set_reg(REG_IMAGE_HEIGHT, f.h);
        if (all_regs || f.cols != cfg_cols || $urandom_range(1)) set_reg(REG_GRID_COLS, f.cols);
        if (all_regs || f.rows != cfg_rows || $urandom_range(1)) set_reg(REG_GRID_ROWS, f.rows);
        npix = frame_pixels();
        for (k = 0; k < npix; k++) begin
            // a write inside the frame must not touch the latched geometry
            if (f.split != 0 && k == f.split) begin
                i_valid <= 1'b0;
                settle();
                set_reg(REG_GRID_COLS, f.split_cols);
            end
            send_pixel(make_pixel(f.mode, f.color), f.typed, f.want);
        end
        i_valid <= 1'b0;
        settle();
    endtask

    task automatic add_frame(input int unsigned w, input int unsigned h, input int unsigned cols,
                             input int unsigned rows, input pix_mode_e mode,
                             input logic [23:0] color, input bit typed, input t_result want,
                             input int unsigned split, input int unsigned split_cols);
        frame_t f;
        f.w = w;
        f.h = h;
        f.cols = cols;
        f.rows = rows;
        f.mode = mode;
        f.color = color;
        f.typed = typed;
        f.want = want;
        f.split = split;
        f.split_cols = split_cols;
        plan.push_back(f);
    endtask

    initial begin
        frame_t      f;
        int unsigned roll;
        int unsigned n;
        t_result     none;
        none = '0;

        // single-pixel frames: black, white, and both sides of the luma threshold
        add_frame(1, 1, 1, 1, PIX_FIXED, 24'h000000, 1, mk_cell(1, 1, 0), 0, 0);
        add_frame(1, 1, 1, 1, PIX_FIXED, 24'hFFFFFF, 1, mk_cell(0, 1, 0), 0, 0);
        add_frame(1, 1, 1, 1, PIX_FIXED, 24'h7F7F7F, 1, mk_cell(1, 1, 0), 0, 0);
        add_frame(1, 1, 1, 1, PIX_FIXED, 24'h808080, 1, mk_cell(0, 1, 0), 0, 0);
        // zero cell size: grid larger than image, zero registers
        add_frame(1, 1, 2, 1, PIX_FIXED, 24'h000000, 1, mk_cell(0, 0, 1), 0, 0);
        add_frame(0, 5, 1, 1, PIX_RANDOM, 24'h0, 1, mk_cell(0, 0, 1), 0, 0);
        add_frame(3, 0, 1, 1, PIX_RANDOM, 24'h0, 1, mk_cell(0, 0, 1), 0, 0);
        add_frame(4, 2, 0, 1, PIX_RANDOM, 24'h0, 1, mk_cell(0, 0, 1), 0, 0);
        add_frame(4, 2, 1, 0, PIX_RANDOM, 24'h0, 1, mk_cell(0, 0, 1), 0, 0);
        add_frame(2, 3, 1, 4, PIX_RANDOM, 24'h0, 1, mk_cell(0, 0, 1), 0, 0);
        // remainder cells, one-pixel cells, a grid change inside a frame
        add_frame(7, 5, 3, 2, PIX_RANDOM, 24'h0, 0, none, 0, 0);
        add_frame(5, 3, 5, 3, PIX_GRAY_EDGE, 24'h0, 0, none, 0, 0);
        add_frame(6, 4, 2, 2, PIX_RANDOM, 24'h0, 0, none, 10, 3);
        add_frame(9, 4, 3, 1, PIX_DARKISH, 24'h0, 0, none, 0, 0);
        // oversized registers saturate; images and grids at the maximum sizes
        add_frame(2047, 1, 127, 1, PIX_RANDOM, 24'h0, 0, none, 0, 0);
        add_frame(1, 2047, 1, 127, PIX_BRIGHTISH, 24'h0, 0, none, 0, 0);
        add_frame(1024, 1, 3, 1, PIX_GRAY_EDGE, 24'h0, 0, none, 0, 0);
        add_frame(100, 1, 64, 1, PIX_RANDOM, 24'h0, 0, none, 0, 0);
        add_frame(1, 70, 1, 64, PIX_DARKISH, 24'h0, 0, none, 0, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < plan.size(); n++) begin
            run_frame(plan[n], 1'b1);
        end

        fed = 0;
        while (fed < RAND_PIX) begin
            calm = (fed >= 700 && fed < 1000);
            f.typed = 1'b0;
            f.want = '0;
            f.color = 24'($urandom);
            f.mode = pix_mode_e'($urandom_range(0, 4));
            f.split = ($urandom_range(19) == 0) ? $urandom_range(1, 20) : 0;
            f.split_cols = $urandom_range(1, 8);
            roll = $urandom_range(99);
            if (roll < 8) begin
                // broken geometry, kept small since its pixels are dropped
                f.w = $urandom_range(1, 8);
                f.h = $urandom_range(1, 6);
                f.cols = $urandom_range(1, f.w);
                f.rows = $urandom_range(1, f.h);
                case ($urandom_range(3))
                    0: f.cols = $urandom_range(f.w + 1, 127);
                    1: f.rows = $urandom_range(f.h + 1, 127);
                    2: begin
                        if ($urandom_range(1)) f.w = 0;
                        else f.h = 0;
                    end
                    default: begin
                        if ($urandom_range(1)) f.cols = 0;
                        else f.rows = 0;
                    end
                endcase
            end else begin
                f.w = ($urandom_range(9) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
                if (f.w > 16) f.h = $urandom_range(1, 3);
                else if ($urandom_range(9) == 0) f.h = $urandom_range(11, 40);
                else f.h = $urandom_range(1, 10);
                f.cols = $urandom_range(1, (f.w < 64) ? f.w : 64);
                f.rows = $urandom_range(1, (f.h < 64) ? f.h : 64);
                if (f.w >= 64 && $urandom_range(1)) f.cols = $urandom_range(65, 127);
            end
            run_frame(f, 1'b0);
        end
        calm = 1'b0;
        settle();

        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
